>>> hdl/mcwq_pkg.sv
// package: types, constants and codes for the wait-queue unit
package mcwq_pkg;

  localparam int NUM_OBJECTS_DEF = 32;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int PID_BITS_DEF    = 8;
  localparam int MAX_RESULTS     = 16;

  localparam int CMD_W = 3;
  localparam int ST_W  = 3;
  localparam int IDX_W = 5;
  localparam int PIDF_W = 8;

  typedef enum logic [2:0] {
    CMD_NEW_LOCK  = 3'd0,
    CMD_ACQUIRE   = 3'd1,
    CMD_RELEASE   = 3'd2,
    CMD_NEW_CVAR  = 3'd3,
    CMD_SIGNAL    = 3'd4,
    CMD_BROADCAST = 3'd5,
    CMD_WAIT      = 3'd6,
    CMD_NONE      = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    ST_ACQUIRED = 3'd0,
    ST_BLOCKED  = 3'd1,
    ST_FREED    = 3'd2,
    ST_HANDED   = 3'd3,
    ST_CREATED  = 3'd4,
    ST_WOKEN    = 3'd5,
    ST_ERROR    = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_LOCK = 2'd1,
    KIND_CVAR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_CVREAD,
    S_CVEXEC,
    S_BCAST,
    S_OUT
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_EXEC,
    OP_CVEXEC,
    OP_BCPOP,
    OP_BCDONE
  } op_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic rd_lk;
    logic rd_cv;
    op_t  op;
    logic out_set;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic needs_cv;
    logic bc_start;
    logic bc_more;
  } sts_t;

endpackage

>>> hdl/mcwq_ctrl.sv
// controller state machine for the wait-queue unit
module mcwq_ctrl import mcwq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output ctl_t ctl
);

  state_t state, state_next;
  logic   ovalid, ovalid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ovalid <= 1'b0;
    end else begin
      state  <= state_next;
      ovalid <= ovalid_next;
    end
  end

  assign out_valid = ovalid;
  assign in_stall  = (state != S_IDLE);

  always_comb begin
    state_next  = state;
    ovalid_next = ovalid;
    ctl         = '0;
    ctl.op      = OP_NONE;
    if (ovalid && !out_stall) ovalid_next = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        ctl.rd_lk  = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (sts.needs_cv) begin
          state_next = S_CVREAD;
        end else begin
          ctl.op     = OP_EXEC;
          state_next = S_OUT;
        end
      end
      S_CVREAD: begin
        ctl.rd_cv  = 1'b1;
        state_next = S_CVEXEC;
      end
      S_CVEXEC: begin
        if (sts.bc_start) begin
          state_next = S_BCAST;
        end else begin
          ctl.op     = OP_CVEXEC;
          state_next = S_OUT;
        end
      end
      S_BCAST: begin
        if (!ovalid || !out_stall) begin
          ctl.op      = OP_BCPOP;
          ctl.out_set = 1'b1;
          ovalid_next = 1'b1;
          if (!sts.bc_more) state_next = S_IDLE;
        end
      end
      S_OUT: begin
        if (!ovalid || !out_stall) begin
          ctl.out_set = 1'b1;
          ovalid_next = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> hdl/mcwq_dp.sv
// datapath: object table, queue memory and result register
module mcwq_dp import mcwq_pkg::*; #(
  parameter int NUM_OBJECTS = NUM_OBJECTS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int PID_BITS    = PID_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  ctl_t              ctl,
  output sts_t              sts,
  input  logic [CMD_W-1:0]  cmd,
  input  logic [PIDF_W-1:0] caller_pid,
  input  logic [IDX_W-1:0]  lock_index,
  input  logic [IDX_W-1:0]  cvar_index,
  output logic [ST_W-1:0]   status,
  output logic [PIDF_W-1:0] result_pid,
  output logic [IDX_W-1:0]  new_id,
  output logic              last
);

  localparam int OW  = (NUM_OBJECTS > 1) ? $clog2(NUM_OBJECTS) : 1;
  localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int NW  = $clog2(NUM_OBJECTS + 1);
  localparam int MW  = OW + QW;
  localparam int RW  = $clog2(MAX_RESULTS + 1);
  localparam int MEMD = NUM_OBJECTS * QUEUE_DEPTH;

  // per-object control state; kind, held, queue head and count are cleared at reset, owner is not
  logic [1:0]          kind  [NUM_OBJECTS];
  logic                held  [NUM_OBJECTS];
  logic [QW-1:0]       qhead [NUM_OBJECTS];
  logic [CW-1:0]       qcnt  [NUM_OBJECTS];
  logic [PID_BITS-1:0] owner [NUM_OBJECTS];
  logic [PID_BITS-1:0] wmem  [MEMD];
  logic [NW-1:0]       next_id;

  cmd_t                c_cmd;
  logic [PID_BITS-1:0] c_pid;
  logic [IDX_W-1:0]    c_lk, c_cv;

  // registered snapshot of the entry in work
  logic                o_ok;
  logic [OW-1:0]       o_idx;
  logic [1:0]          o_kind;
  logic                o_held;
  logic [PID_BITS-1:0] o_owner;
  logic [QW-1:0]       o_head;
  logic [CW-1:0]       o_cnt;
  logic [PID_BITS-1:0] o_front;

  logic [ST_W-1:0]     r_st;
  logic [PID_BITS-1:0] r_pid;
  logic [IDX_W-1:0]    r_id;
  logic [RW-1:0]       bc_n;

  logic [ST_W-1:0]   st_reg;
  logic [PIDF_W-1:0] pid_reg;
  logic [IDX_W-1:0]  id_reg;
  logic              last_reg;

  logic [OW-1:0] rd_idx;
  logic          rd_ok;
  logic [IDX_W-1:0] rd_raw;

  always_comb begin
    rd_raw = ctl.rd_cv ? c_cv : c_lk;
    rd_ok  = ({{(32-IDX_W){1'b0}}, rd_raw} < NUM_OBJECTS);
    rd_idx = OW'(rd_raw);
  end

  function automatic logic [MW-1:0] maddr(input logic [OW-1:0] o, input logic [QW-1:0] s);
    maddr = MW'(o) * MW'(QUEUE_DEPTH) + MW'(s);
  endfunction

  logic         rel_err, rel_empty;
  logic [QW-1:0] head_inc, tail_pos;
  logic [CW:0]   tail_sum;
  logic         q_full;

  always_comb begin
    rel_err   = !o_ok || (o_kind != KIND_LOCK) || !o_held || (o_owner != c_pid);
    rel_empty = (o_cnt == '0);
    head_inc  = (o_head == QW'(QUEUE_DEPTH - 1)) ? '0 : o_head + 1'b1;
    tail_sum  = (CW+1)'(o_head) + (CW+1)'(o_cnt);
    tail_pos  = (tail_sum >= (CW+1)'(QUEUE_DEPTH)) ?
                QW'(tail_sum - (CW+1)'(QUEUE_DEPTH)) : QW'(tail_sum);
    q_full    = (o_cnt >= CW'(QUEUE_DEPTH));
  end

  // wait reads the lock first, then the cvar, and checks both together
  always_comb begin
    sts.needs_cv  = (c_cmd == CMD_SIGNAL) || (c_cmd == CMD_BROADCAST) ||
                    (c_cmd == CMD_WAIT);
    sts.bc_start  = (c_cmd == CMD_BROADCAST) && o_ok && (o_kind == KIND_CVAR) &&
                    (o_cnt != '0);
    sts.bc_more   = (o_cnt > CW'(1)) && (bc_n + 1'b1 < RW'(MAX_RESULTS));
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      c_cmd <= cmd_t'(cmd);
      c_pid <= PID_BITS'(caller_pid);
      c_lk  <= lock_index;
      c_cv  <= cvar_index;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_lk || ctl.rd_cv) begin
      o_ok    <= rd_ok;
      o_idx   <= rd_idx;
      o_kind  <= kind[rd_idx];
      o_held  <= held[rd_idx];
      o_owner <= owner[rd_idx];
      o_head  <= qhead[rd_idx];
      o_cnt   <= qcnt[rd_idx];
      o_front <= wmem[maddr(rd_idx, qhead[rd_idx])];
      bc_n    <= '0;
    end else if (ctl.op == OP_BCPOP) begin
      o_head  <= head_inc;
      o_cnt   <= o_cnt - 1'b1;
      o_front <= wmem[maddr(o_idx, head_inc)];
      bc_n    <= bc_n + 1'b1;
    end
  end

  // saved lock snapshot for wait (lock read first)
  logic [OW-1:0]       l_idx;
  logic                l_rel_err, l_empty;
  logic [QW-1:0]       l_head_inc;
  logic [PID_BITS-1:0] l_front;

  always_ff @(posedge clk) begin
    if (ctl.rd_cv) begin
      l_idx      <= o_idx;
      l_rel_err  <= rel_err;
      l_empty    <= rel_empty;
      l_head_inc <= head_inc;
      l_front    <= o_front;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      next_id <= '0;
      for (int i = 0; i < NUM_OBJECTS; i++) begin
        kind[i]  <= KIND_NONE;
        held[i]  <= 1'b0;
        qhead[i] <= '0;
        qcnt[i]  <= '0;
      end
    end else begin
      if (ctl.op == OP_EXEC) begin
        r_st  <= ST_ERROR;
        r_pid <= '0;
        r_id  <= '0;
        case (c_cmd)
          CMD_NEW_LOCK, CMD_NEW_CVAR: begin
            if (next_id < NW'(NUM_OBJECTS)) begin
              kind[OW'(next_id)]  <= (c_cmd == CMD_NEW_LOCK) ? KIND_LOCK : KIND_CVAR;
              held[OW'(next_id)]  <= 1'b0;
              qhead[OW'(next_id)] <= '0;
              qcnt[OW'(next_id)]  <= '0;
              next_id <= next_id + 1'b1;
              r_st <= ST_CREATED;
              r_id <= IDX_W'(next_id);
            end
          end
          CMD_ACQUIRE: begin
            if (o_ok && o_kind == KIND_LOCK) begin
              if (!o_held) begin
                held[o_idx]  <= 1'b1;
                owner[o_idx] <= c_pid;
                r_st  <= ST_ACQUIRED;
                r_pid <= c_pid;
              end else if (o_owner != c_pid && !q_full) begin
                wmem[maddr(o_idx, tail_pos)] <= c_pid;
                qcnt[o_idx] <= o_cnt + 1'b1;
                r_st <= ST_BLOCKED;
              end
            end
          end
          CMD_RELEASE: begin
            if (!rel_err) begin
              if (rel_empty) begin
                held[o_idx] <= 1'b0;
                r_st <= ST_FREED;
              end else begin
                owner[o_idx] <= o_front;
                qhead[o_idx] <= head_inc;
                qcnt[o_idx]  <= o_cnt - 1'b1;
                r_st  <= ST_HANDED;
                r_pid <= o_front;
              end
            end
          end
          default: ;
        endcase
      end else if (ctl.op == OP_CVEXEC) begin
        r_st  <= ST_ERROR;
        r_pid <= '0;
        r_id  <= '0;
        if (o_ok && o_kind == KIND_CVAR) begin
          if (c_cmd == CMD_SIGNAL) begin
            if (!rel_empty) begin
              qhead[o_idx] <= head_inc;
              qcnt[o_idx]  <= o_cnt - 1'b1;
              r_st  <= ST_WOKEN;
              r_pid <= o_front;
            end
          end else if (c_cmd == CMD_WAIT && !l_rel_err) begin
            // release takes effect even when the cvar queue is full
            if (l_empty) begin
              held[l_idx] <= 1'b0;
            end else begin
              owner[l_idx] <= l_front;
              qhead[l_idx] <= l_head_inc;
              qcnt[l_idx]  <= qcnt[l_idx] - 1'b1;
            end
            if (!q_full) begin
              wmem[maddr(o_idx, tail_pos)] <= c_pid;
              qcnt[o_idx] <= o_cnt + 1'b1;
              r_st  <= l_empty ? ST_FREED : ST_HANDED;
              r_pid <= l_empty ? '0 : l_front;
            end
          end
        end
      end else if (ctl.op == OP_BCPOP) begin
        qhead[o_idx] <= head_inc;
        qcnt[o_idx]  <= o_cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_set) begin
      if (ctl.op == OP_BCPOP) begin
        st_reg   <= ST_WOKEN;
        pid_reg  <= PIDF_W'(o_front);
        id_reg   <= '0;
        last_reg <= !sts.bc_more;
      end else begin
        st_reg   <= r_st;
        pid_reg  <= PIDF_W'(r_pid);
        id_reg   <= r_id;
        last_reg <= 1'b1;
      end
    end
  end

  assign status     = st_reg;
  assign result_pid = pid_reg;
  assign new_id     = id_reg;
  assign last       = last_reg;

endmodule

>>> hdl/mutex_condvar_wait_queue_unit.sv
// top level: mutex and condition variable wait-queue unit
//
// channel  direction  fields                                   handshake
// in       input      cmd caller_pid lock_index cvar_index     in_valid / in_stall
// out      output     status result_pid new_id last            out_valid / out_stall
//
// one item at a time; lock-side commands pass the read, exec and out states, cvar commands
// also cvread and cvexec, for the registered reads of the object table and queue memory
// broadcast then gives one result per cycle while out is not stalled
// reset clears the table control state directly; no clearing pass
// the result register holds while out_stall is high
module mutex_condvar_wait_queue_unit import mcwq_pkg::*; #(
  parameter int NUM_OBJECTS = NUM_OBJECTS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int PID_BITS    = PID_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CMD_W-1:0]  cmd,
  input  logic [PIDF_W-1:0] caller_pid,
  input  logic [IDX_W-1:0]  lock_index,
  input  logic [IDX_W-1:0]  cvar_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ST_W-1:0]   status,
  output logic [PIDF_W-1:0] result_pid,
  output logic [IDX_W-1:0]  new_id,
  output logic              last
);

  ctl_t ctl;
  sts_t sts;

  mcwq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  mcwq_dp #(
    .NUM_OBJECTS (NUM_OBJECTS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PID_BITS    (PID_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .sts        (sts),
    .cmd        (cmd),
    .caller_pid (caller_pid),
    .lock_index (lock_index),
    .cvar_index (cvar_index),
    .status     (status),
    .result_pid (result_pid),
    .new_id     (new_id),
    .last       (last)
  );

endmodule
